FILE: rtl/core/tcl_pkg.sv
// Shared types and codes for the text cursor layout block.
package tcl_pkg;

  // Request types on the input channel
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_CHAR  = 1'b1;

  // Result kinds on the output channel
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Control characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Newline count saturates here
  localparam logic [4:0] LINE_MAX = 5'd31;

  // Result queue geometry
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  // Number of results produced by one transfer
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [8:0] glyph_x;
    logic [7:0] glyph_y;
    logic [7:0] glyph_code;
    logic [7:0] glyph_ink;
    logic [4:0] line_count;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: rtl/core/tcl_cursor.sv
// Cursor state registers and the per-character layout step.
module tcl_cursor import tcl_pkg::*; #(
  parameter int SCREEN_COLS  = 40,
  parameter int SCREEN_ROWS  = 25,
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8,
  parameter int TAB_STOP     = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       req_type_i,
  input  logic [8:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [5:0] column_limit_i,
  input  logic [4:0] row_limit_i,
  input  logic [7:0] ink_i,
  input  logic [7:0] char_code_i,
  output push_t      push_o
);

  localparam int COL_W = $clog2(SCREEN_COLS + TAB_STOP + 1);
  localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
  localparam int CX_W  = $clog2(SCREEN_COLS + 1);
  localparam int CY_W  = $clog2(SCREEN_ROWS + 1);
  localparam int CL_W  = (COL_W > 6) ? COL_W : 6;
  localparam int RL_W  = (ROW_W > 5) ? ROW_W : 5;
  localparam int TABS  = (SCREEN_COLS - 1) / TAB_STOP;

  logic [8:0]       origin_x_q, origin_x_d;
  logic [7:0]       cursor_y_q, cursor_y_d;
  logic [COL_W-1:0] cursor_col_q, cursor_col_d;
  logic [COL_W-1:0] col_budget_q, col_budget_d;
  logic [ROW_W-1:0] rows_left_q, rows_left_d;
  logic [4:0]       newline_total_q, newline_total_d;
  logic [7:0]       held_ink_q, held_ink_d;
  logic             active_q, active_d;

  logic [CX_W-1:0]  cx;
  logic [CY_W-1:0]  cy;
  logic [COL_W-1:0] cols;
  logic [ROW_W-1:0] rows;
  logic [COL_W-1:0] tab_col;
  logic [COL_W-1:0] col_adv;
  logic [ROW_W-1:0] rows_dec;
  logic [4:0]       nl_inc;
  logic             off_screen;
  logic             do_row;
  logic             do_glyph;
  result_t          glyph_res;
  result_t          done_res;
  push_t            push;

  // Convert the start position to a cell position by threshold compares
  always_comb begin
    cx = '0;
    for (int k = 1; k <= SCREEN_COLS; k++) begin
      if (32'(start_x_i) >= 32'(k * GLYPH_WIDTH)) begin
        cx = CX_W'(k);
      end
    end
    cy = '0;
    for (int k = 1; k <= SCREEN_ROWS; k++) begin
      if (32'(start_y_i) >= 32'(k * GLYPH_HEIGHT)) begin
        cy = CY_W'(k);
      end
    end
  end

  assign off_screen = (32'(start_x_i) >= 32'(SCREEN_COLS * GLYPH_WIDTH)) ||
                      (32'(start_y_i) >= 32'(SCREEN_ROWS * GLYPH_HEIGHT));

  // Clip the budgets to the caller's limits
  always_comb begin
    cols = COL_W'(SCREEN_COLS) - COL_W'(cx);
    rows = ROW_W'(SCREEN_ROWS) - ROW_W'(cy);
    if (column_limit_i != 6'd0 && CL_W'(column_limit_i) < CL_W'(cols)) begin
      cols = COL_W'(column_limit_i);
    end
    if (row_limit_i != 5'd0 && RL_W'(row_limit_i) < RL_W'(rows)) begin
      rows = ROW_W'(row_limit_i);
    end
  end

  // Find the next tab stop past the cursor
  always_comb begin
    tab_col = COL_W'(TAB_STOP);
    for (int k = 0; k <= TABS; k++) begin
      if (32'(cursor_col_q) >= 32'(k * TAB_STOP)) begin
        tab_col = COL_W'((k + 1) * TAB_STOP);
      end
    end
  end

  assign nl_inc   = (newline_total_q < LINE_MAX) ? newline_total_q + 5'd1 : newline_total_q;
  assign rows_dec = (rows_left_q != '0) ? rows_left_q - ROW_W'(1) : rows_left_q;

  // Build the glyph result
  always_comb begin
    glyph_res            = '0;
    glyph_res.kind       = KIND_GLYPH;
    glyph_res.glyph_x    = origin_x_q + 9'(32'(cursor_col_q) * GLYPH_WIDTH);
    glyph_res.glyph_y    = cursor_y_q;
    glyph_res.glyph_code = char_code_i;
    glyph_res.glyph_ink  = held_ink_q;
  end

  // Layout step: work out the next state and the results to push
  always_comb begin
    origin_x_d      = origin_x_q;
    cursor_y_d      = cursor_y_q;
    cursor_col_d    = cursor_col_q;
    col_budget_d    = col_budget_q;
    rows_left_d     = rows_left_q;
    newline_total_d = newline_total_q;
    held_ink_d      = held_ink_q;
    active_d        = active_q;
    done_res        = '0;
    done_res.kind   = KIND_DONE;
    done_res.last   = 1'b1;
    push            = '0;
    do_row          = 1'b0;
    do_glyph        = 1'b0;
    col_adv         = cursor_col_q;

    if (req_type_i == REQ_START) begin
      active_d = 1'b0;
      if (off_screen) begin
        push.n  = PUSH_ONE;
        push.r0 = done_res;
      end else begin
        origin_x_d      = start_x_i;
        cursor_y_d      = start_y_i;
        cursor_col_d    = '0;
        col_budget_d    = cols;
        rows_left_d     = rows;
        newline_total_d = '0;
        held_ink_d      = ink_i;
        active_d        = 1'b1;
      end
    end else if (active_q) begin
      case (char_code_i)
        CH_NUL: begin
          done_res.line_count = newline_total_q;
          push.n   = PUSH_ONE;
          push.r0  = done_res;
          active_d = 1'b0;
        end
        CH_LF: begin
          do_row = 1'b1;
        end
        CH_CR: begin
          cursor_col_d = '0;
        end
        CH_TAB: begin
          col_adv      = tab_col;
          cursor_col_d = tab_col;
          do_row       = (tab_col >= col_budget_q);
        end
        default: begin
          do_glyph     = (char_code_i != CH_SPACE);
          col_adv      = cursor_col_q + COL_W'(1);
          cursor_col_d = col_adv;
          do_row       = (col_adv >= col_budget_q);
        end
      endcase

      if (do_glyph) begin
        push.n  = PUSH_ONE;
        push.r0 = glyph_res;
      end

      // Take a newline; end the string when the rows run out
      if (do_row) begin
        newline_total_d = nl_inc;
        rows_left_d     = rows_dec;
        if (rows_dec == '0) begin
          done_res.line_count = nl_inc;
          active_d            = 1'b0;
          if (do_glyph) begin
            push.n  = PUSH_TWO;
            push.r1 = done_res;
          end else begin
            push.n  = PUSH_ONE;
            push.r0 = done_res;
          end
        end else begin
          cursor_y_d   = cursor_y_q + 8'(GLYPH_HEIGHT);
          cursor_col_d = '0;
        end
      end
    end
  end

  // Drop the results when nothing is transferred
  always_comb begin
    push_o = push;
    if (!accept_i) begin
      push_o.n = PUSH_NONE;
    end
  end

  // Hold state between transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= '0;
      cursor_y_q      <= '0;
      cursor_col_q    <= '0;
      col_budget_q    <= '0;
      rows_left_q     <= '0;
      newline_total_q <= '0;
      held_ink_q      <= '0;
      active_q        <= 1'b0;
    end else if (accept_i) begin
      origin_x_q      <= origin_x_d;
      cursor_y_q      <= cursor_y_d;
      cursor_col_q    <= cursor_col_d;
      col_budget_q    <= col_budget_d;
      rows_left_q     <= rows_left_d;
      newline_total_q <= newline_total_d;
      held_ink_q      <= held_ink_d;
      active_q        <= active_d;
    end
  end

  // A running string always has its cursor inside the column budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cursor_col_q < col_budget_q))
    else $error("cursor column outside budget while active");

  // A running string always has at least one row left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (rows_left_q != '0))
    else $error("active string with no rows left");

  // Two results only come from a glyph that also ends the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n == PUSH_TWO) |-> (push_o.r0.kind == KIND_GLYPH && push_o.r1.last))
    else $error("bad result pair");

endmodule

FILE: rtl/core/tcl_outq.sv
// Result queue: up to two results in per cycle, one out unless stalled.
module tcl_outq import tcl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_res_o
);

  result_t               mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUTQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUTQ_CNT_W-1:0] count_q, count_d;
  logic [OUTQ_PTR_W-1:0] wr_ptr_nx;
  logic                  pop;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign full_o      = (count_q > OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + OUTQ_PTR_W'(1);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + OUTQ_PTR_W'(push_i.n);
    rd_ptr_d = pop ? rd_ptr_q + OUTQ_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + OUTQ_CNT_W'(push_i.n) - OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store results
  always_ff @(posedge clk_i) begin
    if (push_i.n != PUSH_NONE) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == PUSH_TWO) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  // Fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue overflow");

  // Results are pushed only when room for two remains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != PUSH_NONE) |-> !full_o)
    else $error("push into a full result queue");

  // Never push more than two results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd3)
    else $error("invalid push count");

endmodule

FILE: rtl/core/text_cursor_layout_top.sv
// Top level of the text cursor layout engine.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | req_type, start_x/y, limits, ink, char
//  out     | output    | out_valid_o / out_stall_i| kind, glyph_x/y/code/ink, line_count, last
//
// One item is taken per cycle while in_stall_o is low. The cursor step is a
// single pass of logic from the state registers into a four-entry result
// queue, which drains one result per cycle while out_stall_i is low. A glyph
// in the last column that ends the string pushes two results. in_stall_o
// rises while fewer than two queue slots are free. Reset clears the cursor
// to idle and empties the queue; no clearing pass is needed.
module text_cursor_layout_top import tcl_pkg::*; #(
  parameter int SCREEN_COLS  = 40,
  parameter int SCREEN_ROWS  = 25,
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8,
  parameter int TAB_STOP     = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [8:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [5:0] column_limit_i,
  input  logic [4:0] row_limit_i,
  input  logic [7:0] ink_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [8:0] glyph_x_o,
  output logic [7:0] glyph_y_o,
  output logic [7:0] glyph_code_o,
  output logic [7:0] glyph_ink_o,
  output logic [4:0] line_count_o,
  output logic       last_o
);

  logic    accept;
  logic    full;
  push_t   push;
  result_t out_res;

  // Accept a transfer when the queue has room for two results
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  tcl_cursor #(
    .SCREEN_COLS  (SCREEN_COLS),
    .SCREEN_ROWS  (SCREEN_ROWS),
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .TAB_STOP     (TAB_STOP)
  ) u_cursor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .column_limit_i (column_limit_i),
    .row_limit_i    (row_limit_i),
    .ink_i          (ink_i),
    .char_code_i    (char_code_i),
    .push_o         (push)
  );

  tcl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  // Unpack the queue head onto the output fields
  assign kind_o       = out_res.kind;
  assign glyph_x_o    = out_res.glyph_x;
  assign glyph_y_o    = out_res.glyph_y;
  assign glyph_code_o = out_res.glyph_code;
  assign glyph_ink_o  = out_res.glyph_ink;
  assign line_count_o = out_res.line_count;
  assign last_o       = out_res.last;

endmodule
